// ----- design/sha256_pkg.sv -----
package sha256_pkg;

    localparam int unsigned WORD_W = 32;

    // Byte positions inside a 64-byte block
    localparam logic [5:0] POS_LAST = 6'd63;
    localparam logic [5:0] POS_LEN  = 6'd56;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [3:0] DIGEST_WORDS = 4'd8;

    localparam logic [WORD_W-1:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_INIT,
        ST_ROUND,
        ST_ADD,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        AFT_IDLE,
        AFT_PAD,
        AFT_DONE
    } after_t;

    typedef enum logic [1:0] {
        BSEL_DATA,
        BSEL_MARK,
        BSEL_ZERO,
        BSEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      write_byte;
        byte_sel_t byte_sel;
        logic      count_len;
        logic      load_vars;
        logic      round_en;
        logic      add_hash;
        logic      emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] byte_pos;
        logic       round_last;
        logic       out_busy;
    } dp_sts_t;

endpackage

// ----- design/sha256_dp.sv -----
module sha256_dp
    import sha256_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         data_byte,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [WORD_W-1:0]  out_word,
    output logic [2:0]         out_number,
    output logic               out_last
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    logic [WORD_W-1:0] w_reg [16];
    logic [WORD_W-1:0] v_reg [8];
    logic [WORD_W-1:0] hash_reg [8];
    logic [WORD_W-1:0] out_sr_reg [8];
    logic [23:0]       acc_reg;
    logic [5:0]        pos_reg;
    logic [60:0]       msg_len_reg;
    logic [5:0]        round_cnt_reg;
    logic [3:0]        out_cnt_reg;
    logic [2:0]        out_idx_reg;

    logic [7:0]        wr_byte;
    logic [63:0]       len_bits;
    logic [2:0]        len_idx;
    logic [WORD_W-1:0] sched_word;
    logic [WORD_W-1:0] wt;
    logic [WORD_W-1:0] t1;
    logic [WORD_W-1:0] t2;
    logic [WORD_W-1:0] ssig0;
    logic [WORD_W-1:0] ssig1;
    logic              out_fire;

    assign len_bits = {msg_len_reg, 3'b000};
    assign len_idx  = 3'd7 - pos_reg[2:0];

    always_comb begin
        unique case (cmd.byte_sel)
            BSEL_DATA: wr_byte = data_byte;
            BSEL_MARK: wr_byte = PAD_MARK;
            BSEL_LEN:  wr_byte = len_bits[{len_idx, 3'b000} +: 8];
            default:   wr_byte = 8'h00;
        endcase
    end

    assign sched_word = {acc_reg, wr_byte};

    // message schedule word for the current round
    assign ssig0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign ssig1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign wt = (round_cnt_reg[5:4] == 2'b00) ? w_reg[0]
                                              : w_reg[0] + ssig0 + w_reg[9] + ssig1;

    assign t1 = v_reg[7]
              + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + ROUND_K[round_cnt_reg] + wt;
    assign t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // schedule shift line: bytes pack into words, rounds rotate and extend
    always_ff @(posedge aclk) begin
        if (cmd.write_byte) begin
            acc_reg <= {acc_reg[15:0], wr_byte};
        end
        if (cmd.write_byte && pos_reg[1:0] == 2'b11) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= sched_word;
        end else if (cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wt;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_vars) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= hash_reg[i];
            end
        end else if (cmd.round_en) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign out_fire = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            msg_len_reg   <= '0;
            round_cnt_reg <= '0;
            out_cnt_reg   <= '0;
            out_idx_reg   <= '0;
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= INIT_HASH[i];
            end
        end else begin
            if (cmd.write_byte) begin
                pos_reg <= pos_reg + 6'd1;
            end
            if (cmd.count_len) begin
                msg_len_reg <= msg_len_reg + 61'd1;
            end
            if (cmd.load_vars) begin
                round_cnt_reg <= '0;
            end else if (cmd.round_en) begin
                round_cnt_reg <= round_cnt_reg + 6'd1;
            end
            if (cmd.add_hash) begin
                for (int i = 0; i < 8; i++) begin
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
                end
            end
            if (cmd.emit) begin
                pos_reg     <= '0;
                msg_len_reg <= '0;
                out_cnt_reg <= DIGEST_WORDS;
                out_idx_reg <= '0;
                for (int i = 0; i < 8; i++) begin
                    hash_reg[i] <= INIT_HASH[i];
                end
            end else if (out_fire) begin
                out_cnt_reg <= out_cnt_reg - 4'd1;
                out_idx_reg <= out_idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            for (int i = 0; i < 8; i++) begin
                out_sr_reg[i] <= hash_reg[i];
            end
        end else if (out_fire) begin
            for (int i = 0; i < 7; i++) begin
                out_sr_reg[i] <= out_sr_reg[i+1];
            end
        end
    end

    assign out_valid  = (out_cnt_reg != 4'd0);
    assign out_word   = out_sr_reg[0];
    assign out_number = out_idx_reg;
    assign out_last   = (out_idx_reg == 3'd7);

    assign sts.byte_pos   = pos_reg;
    assign sts.round_last = (round_cnt_reg == 6'd63);
    assign sts.out_busy   = out_valid;

endmodule

// ----- design/sha256_ctrl.sv -----
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  logic    in_has_byte,
    input  logic    in_end,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    after_t after_reg;
    after_t after_next;
    logic   pad_first_reg;
    logic   pad_first_next;
    logic   pad_len_reg;
    logic   pad_len_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            after_reg     <= AFT_IDLE;
            pad_first_reg <= 1'b0;
            pad_len_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            after_reg     <= after_next;
            pad_first_reg <= pad_first_next;
            pad_len_reg   <= pad_len_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        after_next     = after_reg;
        pad_first_next = pad_first_reg;
        pad_len_next   = pad_len_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_has_byte) begin
                        cmd.write_byte = 1'b1;
                        cmd.byte_sel   = BSEL_DATA;
                        cmd.count_len  = 1'b1;
                    end
                    if (in_end) begin
                        pad_first_next = 1'b1;
                        pad_len_next   = 1'b0;
                    end
                    if (in_has_byte && sts.byte_pos == POS_LAST) begin
                        state_next = ST_INIT;
                        after_next = in_end ? AFT_PAD : AFT_IDLE;
                    end else if (in_end) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.write_byte = 1'b1;
                if (pad_first_reg) begin
                    cmd.byte_sel   = BSEL_MARK;
                    pad_first_next = 1'b0;
                    pad_len_next   = (sts.byte_pos < POS_LEN);
                end else if (pad_len_reg && sts.byte_pos >= POS_LEN) begin
                    cmd.byte_sel = BSEL_LEN;
                end else begin
                    cmd.byte_sel = BSEL_ZERO;
                end
                if (sts.byte_pos == POS_LAST) begin
                    state_next   = ST_INIT;
                    pad_len_next = 1'b1;
                    after_next   = (!pad_first_reg && pad_len_reg) ? AFT_DONE : AFT_PAD;
                end
            end
            ST_INIT: begin
                cmd.load_vars = 1'b1;
                state_next    = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                if (sts.round_last) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.add_hash = 1'b1;
                unique case (after_reg)
                    AFT_PAD:  state_next = ST_PAD;
                    AFT_DONE: state_next = ST_DONE;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_round_to_add: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && sts.round_last) |=> state_reg == ST_ADD)
        else $error("last round did not lead to the hash update");

    a_block_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.write_byte && sts.byte_pos == POS_LAST) |=> state_reg == ST_INIT)
        else $error("full block not sent to compression");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !sts.out_busy)
        else $error("digest loaded over undelivered words");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.round_en |-> !(cmd.write_byte || cmd.load_vars || cmd.add_hash))
        else $error("round overlaps another datapath command");

endmodule

// ----- design/sha256_hash_core.sv -----
// Intake: one accepted byte per cycle while idle; after a full 64-byte block the input is held while
// the block is compressed (load working variables, 64 rounds, hash update).
// End of message: padding bytes are written and one or two compressions follow, then the
// eight digest words leave an output buffer, one per cycle while m_tready is high.
// Reset: aresetn synchronous, active low; clears the controller, counters and output
// buffer, and loads the initial hash words. The block is ready the cycle after release.
module sha256_hash_core
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input item stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_message
    input  logic        s_tuser,   // [0] has_byte
    // digest stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic        m_tlast,   // last_word
    output logic [2:0]  m_tuser    // [2:0] word_number
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Controller: byte intake, padding sequence, round sequencing, digest hand-off
    sha256_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_has_byte (s_tuser),
        .in_end      (s_tlast),
        .in_ready    (s_tready),
        .sts         (sts),
        .cmd         (cmd)
    );

    // Datapath: word packing, schedule shift line, round unit, hash and output buffer
    sha256_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .data_byte  (s_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_word   (m_tdata),
        .out_number (m_tuser),
        .out_last   (m_tlast)
    );

endmodule

// ----- tb/sha256_digest_checker.sv -----
`timescale 1ns / 100ps

module sha256_digest_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_message
    input  logic        s_tuser,   // [0] has_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] digest_word
    input  logic        m_tlast,   // last_word
    input  logic [2:0]  m_tuser,   // [2:0] word_number
    output int unsigned mismatches,
    output int unsigned digests_pending,
    output int unsigned words_checked
);

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        tail;
    } digest_word_t;

    logic [31:0]  chain_h [8];
    logic [31:0]  sched_w [16];
    logic [60:0]  byte_total;
    digest_word_t digest_words_due [$];
    int unsigned  mismatch_count;
    int unsigned  compared_count;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++) chain_h[i] = SHA_IV[i];
        for (int i = 0; i < 16; i++) sched_w[i] = '0;
        byte_total = '0;
    endfunction

    // One 64-round compression with the rolling 16-word schedule.
    function automatic void compress_block();
        logic [31:0] v [8];
        logic [31:0] wt, w15, w2, s0, s1, t1, t2;
        for (int i = 0; i < 8; i++) v[i] = chain_h[i];
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                wt = sched_w[t];
            end else begin
                w15 = sched_w[(t - 15) & 15];
                w2  = sched_w[(t - 2) & 15];
                s0  = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
                s1  = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
                wt  = sched_w[t & 15] + s0 + sched_w[(t - 7) & 15] + s1;
                sched_w[t & 15] = wt;
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + wt;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
    endfunction

    // Big-endian byte lane; the first byte of a word clears it.
    function automatic void put_octet(input logic [5:0] pos, input logic [7:0] b);
        if (pos[1:0] == 2'd0) sched_w[pos[5:2]] = '0;
        sched_w[pos[5:2]] = sched_w[pos[5:2]]
                            | ({24'h0, b} << ((3 - int'(pos[1:0])) * 8));
    endfunction

    function automatic void absorb_item(input logic [7:0] d, input logic has,
                                        input logic eom);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        digest_word_t dw;
        if (has) begin
            pos = byte_total[5:0];
            put_octet(pos, d);
            byte_total = byte_total + 61'd1;
            if (pos == 6'd63) compress_block();
        end
        if (eom) begin
            pos = byte_total[5:0];
            put_octet(pos, 8'h80);
            for (int i = int'(pos[5:2]) + 1; i < 16; i++) sched_w[i] = '0;
            // no room for the length: spend an extra all-padding block
            if (pos >= 6'd56) begin
                compress_block();
                for (int i = 0; i < 16; i++) sched_w[i] = '0;
            end
            bit_len = {byte_total, 3'b000};
            sched_w[14] = bit_len[63:32];
            sched_w[15] = bit_len[31:0];
            compress_block();
            for (int j = 0; j < 8; j++) begin
                dw.word  = chain_h[j];
                dw.index = 3'(j);
                dw.tail  = (j == 7);
                digest_words_due = {digest_words_due, dw};
            end
            restart_message();
        end
    endfunction

    task automatic note_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        mismatch_count++;
    endtask

    initial begin
        mismatch_count  = 0;
        compared_count  = 0;
        restart_message();
    end

    always @(posedge aclk) begin
        digest_word_t exp_w;
        if (!aresetn) begin
            restart_message();
            digest_words_due.delete();
        end else begin
            // compare before absorbing so an early word cannot hide behind a new message
            if (m_tvalid && m_tready) begin
                if (digest_words_due.size() == 0) begin
                    note_mismatch($sformatf("unexpected digest word %08h index %0d",
                                            m_tdata, m_tuser));
                end else begin
                    exp_w = digest_words_due.pop_front();
                    compared_count++;
                    if (m_tdata !== exp_w.word)
                        note_mismatch($sformatf("digest word %0d: got %08h, want %08h",
                                                exp_w.index, m_tdata, exp_w.word));
                    if (m_tuser !== exp_w.index)
                        note_mismatch($sformatf("word number: got %0d, want %0d",
                                                m_tuser, exp_w.index));
                    if (m_tlast !== exp_w.tail)
                        note_mismatch($sformatf("last flag on word %0d: got %b, want %b",
                                                exp_w.index, m_tlast, exp_w.tail));
                end
            end
            if (s_tvalid && s_tready) absorb_item(s_tdata, s_tuser, s_tlast);
        end
        mismatches      <= mismatch_count;
        digests_pending <= digest_words_due.size();
        words_checked   <= compared_count;
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    // Allow the longest silent stretch (a full block, then padding and two
    // compressions, plus a receiver stall) many times over.
    localparam int unsigned QUIET_LIMIT   = 4000;
    localparam int unsigned RANDOM_ITEMS  = 305;
    localparam int unsigned CALM_AFTER    = 280;
    localparam int unsigned TAIL_CYCLES   = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
    logic        s_tlast = 1'b0;    // end_of_message
    logic        s_tuser = 1'b0;    // [0] has_byte
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [31:0] m_tdata;           // [31:0] digest_word
    logic        m_tlast;           // last_word
    logic [2:0]  m_tuser;           // [2:0] word_number

    int unsigned mismatches;
    int unsigned digests_pending;
    int unsigned words_checked;

    // Stimulus bookkeeping
    int unsigned counted_items = 0;
    int unsigned messages_sent = 0;
    int unsigned bytes_sent    = 0;
    int unsigned longest_msg   = 0;
    bit          calm          = 1'b0;
    bit          tx_gaps       = 1'b1;

    // Receiver stall state
    bit          rx_stalls  = 1'b1;
    int unsigned rx_hold    = 0;
    int unsigned quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sha256_hash_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    sha256_digest_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .digests_pending (digests_pending),
        .words_checked   (words_checked)
    );

    // Receiver: random stall bursts. Flip stalling on and off now and then so
    // some stretches run with no back-pressure at all; drop it entirely in the
    // calm tail of the run.
    always @(posedge aclk) begin
        if (calm || !rx_stalls) begin
            m_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            rx_hold  <= $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
        end
        if ($urandom_range(0, 99) == 0) rx_stalls <= !rx_stalls;
    end

    // Watchdog: end the run if neither channel moves an item for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] watchdog: no item moved for %0d cycles", $time,
                         QUIET_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Offer one item and hold it until the block takes it. Leave tvalid high on
    // return: the caller offers the next item or lowers it in the same step.
    task automatic offer_item(input logic [7:0] d, input logic has, input logic eom);
        if (!calm && tx_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= has;
        s_tlast  <= eom;
        do @(posedge aclk); while (s_tready !== 1'b1);
        counted_items++;
        if (counted_items >= CALM_AFTER + 12) calm = 1'b1;
    endtask

    // Hold the sender until every expected digest word has come back. The
    // pending count is registered, so let it update before looking at it.
    task automatic drain_pending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (digests_pending != 0) @(posedge aclk);
    endtask

    // Send a message of random bytes. Sprinkle empty items with stray data
    // bits; mark the end either on the last byte or on a separate empty item.
    task automatic send_message(input int unsigned len, input bit end_alone);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) offer_item(8'($urandom), 1'b0, 1'b0);
            offer_item(8'($urandom), 1'b1, (i == len - 1) && !end_alone);
        end
        if (len == 0 || end_alone) offer_item(8'($urandom), 1'b0, 1'b1);
        messages_sent++;
        bytes_sent += len;
        if (len > longest_msg) longest_msg = len;
    endtask

    initial begin
        int unsigned len;
        int unsigned random_start;
        int unsigned boundary_lens [3];

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty message (stray data bits on the end item)
        offer_item(8'hA5, 1'b0, 1'b1);
        messages_sent++;
        // one zero byte, end on the same item
        offer_item(8'h00, 1'b1, 1'b1);
        // one all-ones byte, end on an empty item
        offer_item(8'hFF, 1'b1, 1'b0);
        offer_item(8'h5A, 1'b0, 1'b1);
        // "abc" with an ignored empty item in the middle
        offer_item(8'h61, 1'b1, 1'b0);
        offer_item(8'hFF, 1'b0, 1'b0);
        offer_item(8'h62, 1'b1, 1'b0);
        offer_item(8'h63, 1'b1, 1'b1);
        messages_sent += 3;
        bytes_sent    += 5;
        longest_msg    = 3;
        drain_pending();

        // Random: open with lengths around the block boundary (length just
        // fits, extra padding block, exact full block), then mostly short ones.
        random_start = counted_items;
        boundary_lens[0] = 55;
        boundary_lens[1] = $urandom_range(56, 63);
        boundary_lens[2] = 64;
        for (int k = 0; k < 3; k++) begin
            tx_gaps = $urandom_range(0, 2) != 0;
            send_message(boundary_lens[k], $urandom_range(0, 1));
        end
        drain_pending();
        while (counted_items - random_start < RANDOM_ITEMS) begin
            tx_gaps = $urandom_range(0, 2) != 0;
            if ($urandom_range(0, 9) < 7) len = $urandom_range(0, 12);
            else len = $urandom_range(50, 70);
            send_message(len, $urandom_range(0, 1));
            if ($urandom_range(0, 5) == 0) drain_pending();
        end

        // Let everything come back, then idle long enough to catch stray words.
        drain_pending();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Hashed %0d messages, %0d bytes in total, longest %0d bytes,",
                 messages_sent, bytes_sent, longest_msg);
        $display("including empty and block-boundary lengths; %0d digest words compared.",
                 words_checked);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
